// ----- rtl/phe_pkg.sv -----
// Shared types, constants and color helpers for the nearest-neighbor pixel scaler.
package phe_pkg;

  localparam int OUT_LIMIT  = 4096;
  localparam int N_W        = 13;
  localparam int OUT_COL_W  = 12;
  localparam int CALC_W     = 18;
  localparam int CFG_DATA_W = 13;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  typedef enum logic [1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_SRC_WIDTH    = 2'd1,
    CFG_OUT_WIDTH    = 2'd2,
    CFG_COLOR_COUNT  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    FMT_ARGB1555 = 2'd0,
    FMT_PALETTE  = 2'd1,
    FMT_ARGB8888 = 2'd2
  } pix_fmt_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] pixel_value;
    logic [7:0]  palette_index;
    logic [15:0] palette_entry;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [OUT_COL_W-1:0] out_column;
    logic                 row_end;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] pixel_format;
    logic [8:0] color_count;
  } pix_cfg_t;

  // Expands a 5-bit channel to 8 bits as v*255/31, rounded down. Since
  // v*255 = 31*8v + 7v, the result is 8v plus floor(7v/31), and that second
  // term is taken as (7v*265) >> 13, which is exact for every 5-bit v.
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [15:0] prod;
    prod = 16'(v) * 16'd1855;
    return {v, 3'b000} + 8'(prod[15:13]);
  endfunction

  // Converts an ARGB1555 word to RGB888; alpha is dropped.
  function automatic logic [23:0] from1555(input logic [15:0] c);
    return {expand5(c[14:10]), expand5(c[9:5]), expand5(c[4:0])};
  endfunction

endpackage

// ----- rtl/pixel_expand_nearest_hscale.sv -----
// Top level of the nearest-neighbor horizontal scaler with RGB555 and palette expansion.
//
// Input side is a queue: an item transfers when push is high and full is low. An item is
// either a source pixel (kind 0) or a palette write (kind 1); palette writes give no result.
// Result side is a queue as well: the oldest result sits on out_item while empty is low and
// transfers when pop is high. Each source pixel gives zero to MAX_SCALE results, in column
// order, with last set on the final one of that pixel and row_end on the row's last column.
// Configuration registers are written over the cfg channel (cfg_ready is always high); the
// user must write them only while the block is idle, which the block does not enforce. A
// src_width or out_width write restarts the row. A pixel is registered in the decode stage,
// the queue and the back end before its first result. The back end gives one result per
// cycle while results are popped, so more output columns per pixel hold it longer; the
// front end takes one item a cycle while full is low, and palette writes never occupy the
// back end. A four-entry queue between the halves lets the front accept while the result
// side stalls, until it fills and full rises. Reset clears all queues and row state,
// restores register defaults and reloads the row bound; palette contents are not cleared.
module pixel_expand_nearest_hscale #(
  parameter int MAX_SRC_WIDTH = 1024,
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_SCALE     = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  phe_pkg::in_item_t               in_item,
  output logic                            empty,
  input  logic                            pop,
  output phe_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [phe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import phe_pkg::*;

  localparam int SW_W = $clog2(MAX_SRC_WIDTH+1);

  // Configuration registers.
  logic [1:0]  pixel_format;
  logic [10:0] src_width;
  logic [12:0] out_width;
  logic [8:0]  color_count;

  logic        cfg_write;
  logic        restart_req;
  logic        restart_d;

  logic [CALC_W-1:0] src_ext;
  logic [CALC_W-1:0] w_calc;
  logic [CALC_W-1:0] scaled;
  logic [CALC_W-1:0] n_req;
  logic [CALC_W-1:0] n_calc;
  logic [SW_W-1:0]   eff_w;
  logic [N_W-1:0]    eff_n;

  pix_cfg_t    pcfg;
  logic        fifo_push;
  logic        fifo_full;
  logic        fifo_pop;
  logic        fifo_empty;
  logic [23:0] front_rgb;
  logic [23:0] fifo_rgb;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_ARGB1555;
      src_width    <= 11'd256;
      out_width    <= 13'd256;
      color_count  <= 9'd256;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT: pixel_format <= cfg_data[1:0];
        CFG_SRC_WIDTH:    src_width    <= cfg_data[10:0];
        CFG_OUT_WIDTH:    out_width    <= cfg_data;
        CFG_COLOR_COUNT:  color_count  <= cfg_data[8:0];
        default:          pixel_format <= pixel_format;
      endcase
    end
  end

  // Effective widths: zero source width counts as one, the source width saturates at the
  // maximum, zero output width means no scaling, and the output width is clamped to
  // MAX_SCALE times the source width and to the column limit.
  assign src_ext = CALC_W'(src_width);
  assign w_calc  = (src_ext == '0) ? CALC_W'(1) :
                   (src_ext > CALC_W'(MAX_SRC_WIDTH)) ? CALC_W'(MAX_SRC_WIDTH) : src_ext;
  assign scaled  = w_calc * CALC_W'(MAX_SCALE);
  assign n_req   = (out_width == '0) ? w_calc :
                   (CALC_W'(out_width) > scaled) ? scaled : CALC_W'(out_width);
  assign n_calc  = (n_req > CALC_W'(OUT_LIMIT)) ? CALC_W'(OUT_LIMIT) : n_req;

  always_ff @(posedge clk) begin
    eff_w <= SW_W'(w_calc);
    eff_n <= N_W'(n_calc);
  end

  // The row restart is delayed through restart_req and restart_d so that it sees the registered widths.
  always_ff @(posedge clk) begin
    if (rst) begin
      restart_req <= 1'b1;
      restart_d   <= 1'b0;
    end else begin
      restart_req <= cfg_write &&
                     ((cfg_index == CFG_SRC_WIDTH) || (cfg_index == CFG_OUT_WIDTH));
      restart_d   <= restart_req;
    end
  end

  assign pcfg.pixel_format = pixel_format;
  assign pcfg.color_count  = color_count;

  phe_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (pcfg),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .fifo_full (fifo_full),
    .fifo_push (fifo_push),
    .fifo_rgb  (front_rgb)
  );

  phe_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fifo_push),
    .wr_data  (front_rgb),
    .is_full  (fifo_full),
    .rd_en    (fifo_pop),
    .is_empty (fifo_empty),
    .rd_data  (fifo_rgb)
  );

  phe_back #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SCALE     (MAX_SCALE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .eff_w       (eff_w),
    .eff_n       (eff_n),
    .row_restart (restart_d),
    .fifo_empty  (fifo_empty),
    .fifo_rgb    (fifo_rgb),
    .fifo_pop    (fifo_pop),
    .pop         (pop),
    .empty       (empty),
    .out_item    (out_item)
  );

  // The last column of a row is always the last result of its source pixel.
  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.row_end) |-> out_item.last)
    else $error("row_end result without last");

  // Every result column lies inside the effective output row.
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ({1'b0, out_item.out_column} < eff_n))
    else $error("result column beyond output width");

  // Reset leaves both queue sides idle.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not idle after reset");

endmodule

// ----- rtl/phe_front.sv -----
// Front end: accepts items, writes the palette and decodes source pixels to RGB888.
module phe_front #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  phe_pkg::pix_cfg_t cfg,
  input  logic              push,
  output logic              full,
  input  phe_pkg::in_item_t in_item,
  input  logic              fifo_full,
  output logic              fifo_push,
  output logic [23:0]       fifo_rgb
);
  import phe_pkg::*;

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] PAL_LIM = 9'(PALETTE_DEPTH);

  logic [23:0] palette_mem [PALETTE_DEPTH];
  logic [23:0] rd_data;
  logic        s1_valid;
  logic        s1_pal;
  logic [23:0] s1_rgb;
  logic        accept_pix;
  logic        accept_pal;
  logic [8:0]  pix_idx;
  logic        idx_black;

  assign full       = s1_valid && fifo_full;
  assign accept_pix = push && !full && !in_item.kind;
  assign accept_pal = push && !full && in_item.kind;
  assign fifo_push  = s1_valid && !fifo_full;
  assign fifo_rgb   = s1_pal ? rd_data : s1_rgb;

  assign pix_idx   = {1'b0, in_item.pixel_value[7:0]};
  assign idx_black = (pix_idx >= cfg.color_count) || (pix_idx >= PAL_LIM);

  // Palette entries are converted on write so a read gives RGB888 directly.
  always_ff @(posedge clk) begin
    if (accept_pal && ({1'b0, in_item.palette_index} < PAL_LIM)) begin
      palette_mem[in_item.palette_index[PAL_AW-1:0]] <= from1555(in_item.palette_entry);
    end
    if (accept_pix) begin
      rd_data <= palette_mem[in_item.pixel_value[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept_pix || (s1_valid && fifo_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept_pix) begin
      s1_pal <= (cfg.pixel_format == FMT_PALETTE) && !idx_black;
      unique case (cfg.pixel_format)
        FMT_ARGB1555: s1_rgb <= from1555(in_item.pixel_value[15:0]);
        FMT_PALETTE:  s1_rgb <= 24'd0;
        default:      s1_rgb <= in_item.pixel_value[23:0];
      endcase
    end
  end

endmodule

// ----- rtl/phe_fifo.sv -----
// Short queue of decoded pixels between the front end and the scaler back end.
module phe_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [23:0] wr_data,
  output logic        is_full,
  input  logic        rd_en,
  output logic        is_empty,
  output logic [23:0] rd_data
);
  import phe_pkg::*;

  logic [23:0]   entries [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_AW:0]   count;

  assign is_full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign is_empty = (count == '0);
  assign rd_data  = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + Q_AW'(1);
      end
      if (rd_en) begin
        rptr <= rptr + Q_AW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + (Q_AW+1)'(1);
        2'b01:   count <= count - (Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/phe_back.sv -----
// Back end: walks the row accumulators and emits the output columns of each source pixel.
module phe_back #(
  parameter int MAX_SRC_WIDTH = 1024,
  parameter int MAX_SCALE     = 4
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [$clog2(MAX_SRC_WIDTH+1)-1:0]       eff_w,
  input  logic [phe_pkg::N_W-1:0]                  eff_n,
  input  logic                                     row_restart,
  input  logic                                     fifo_empty,
  input  logic [23:0]                              fifo_rgb,
  output logic                                     fifo_pop,
  input  logic                                     pop,
  output logic                                     empty,
  output phe_pkg::out_item_t                       out_item
);
  import phe_pkg::*;

  localparam int SW_W  = $clog2(MAX_SRC_WIDTH+1);
  localparam int ACC_W = $clog2(OUT_LIMIT*MAX_SRC_WIDTH+1);
  localparam int CNT_W = $clog2(MAX_SCALE+1);

  logic             busy;
  logic [23:0]      cur_rgb;
  logic [CNT_W-1:0] cnt;
  logic [SW_W-1:0]  src_col;
  logic [N_W-1:0]   ocol;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] bound;
  logic             out_valid;

  logic [CNT_W-1:0] cnt_inc;
  logic [N_W-1:0]   ocol_inc;
  logic [ACC_W-1:0] acc_inc;
  logic [SW_W-1:0]  src_inc;
  logic             cond;
  logic             cond_next;
  logic             slot_free;
  logic             emit;
  logic             finish;

  assign cnt_inc  = cnt + CNT_W'(1);
  assign ocol_inc = ocol + N_W'(1);
  assign acc_inc  = acc + ACC_W'(eff_w);
  assign src_inc  = src_col + SW_W'(1);

  assign cond      = (cnt < CNT_W'(MAX_SCALE)) && (ocol < eff_n) && (acc < bound);
  assign cond_next = (cnt_inc < CNT_W'(MAX_SCALE)) && (ocol_inc < eff_n) && (acc_inc < bound);
  assign slot_free = !out_valid || pop;
  assign emit      = busy && cond && slot_free;
  assign finish    = busy && (!cond || (emit && !cond_next));
  assign fifo_pop  = (!busy || finish) && !fifo_empty;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      src_col   <= '0;
      ocol      <= '0;
      acc       <= '0;
      cnt       <= '0;
    end else begin
      if (fifo_pop) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (emit) begin
        cnt <= cnt_inc;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end

      // A row restart comes from reset or a width write, which the user must make only while no pixel is busy.
      if (row_restart || (finish && (src_inc >= eff_w))) begin
        src_col <= '0;
        ocol    <= '0;
        acc     <= '0;
      end else begin
        if (finish) begin
          src_col <= src_inc;
        end
        if (emit) begin
          ocol <= ocol_inc;
          acc  <= acc_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_restart || (finish && (src_inc >= eff_w))) begin
      bound <= ACC_W'(eff_n);
    end else if (finish) begin
      bound <= bound + ACC_W'(eff_n);
    end
    if (fifo_pop) begin
      cur_rgb <= fifo_rgb;
    end
    if (emit) begin
      out_item.red        <= cur_rgb[23:16];
      out_item.green      <= cur_rgb[15:8];
      out_item.blue       <= cur_rgb[7:0];
      out_item.out_column <= ocol[OUT_COL_W-1:0];
      out_item.row_end    <= (ocol_inc == eff_n);
      out_item.last       <= !cond_next;
    end
  end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the nearest-neighbor pixel scaler with palette and RGB555 expansion.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import phe_pkg::*;

  // These match the block's parameters. The scaler is built with them explicitly,
  // so the predictor and the hardware agree on the clamps.
  localparam int unsigned SRC_LIMIT   = 1024;
  localparam int unsigned PAL_SLOTS   = 256;
  localparam int unsigned SCALE_LIMIT = 4;
  // Idle cycles let pass before and after a register write. This covers the
  // block's pipeline and the row-bound reload that follows a width change.
  localparam int SETTLE = 8;
  localparam int DRAIN_LIMIT = 20000;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_expand_nearest_hscale #(
    .MAX_SRC_WIDTH(SRC_LIMIT),
    .PALETTE_DEPTH(PAL_SLOTS),
    .MAX_SCALE(SCALE_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_item(in_item),
    .empty(empty),
    .pop(pop),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state. It is a shadow of the block's registers, palette and row
  // position, updated in transfer order.
  logic [1:0]  cur_format;
  logic [10:0] cur_src_width;
  logic [12:0] cur_out_width;
  logic [8:0]  cur_colors;
  logic [23:0] palette_rgb [PAL_SLOTS];
  bit          slot_written [PAL_SLOTS];
  logic [7:0]  written_slots [$];
  int unsigned src_col;
  int unsigned out_col;
  int unsigned out_acc;
  int unsigned src_bound;

  // Output pixels that have been predicted but not yet popped, oldest first.
  out_item_t pixels_due [$];

  // Idling on both sides is enabled only while this is set.
  bit idle_allowed;
  int mismatches;
  int items_sent;
  int results_seen;
  int settings_used;
  int waited;
  out_item_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hard stop in case the block hangs or stops producing results.
  initial begin
    #2_000_000;
    $display("pixel_expand_nearest_hscale regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // A zero source width counts as one, and wide rows saturate at the limit.
  function automatic int unsigned row_src_width();
    int unsigned w;
    w = cur_src_width;
    if (w == 0) w = 1;
    if (w > SRC_LIMIT) w = SRC_LIMIT;
    return w;
  endfunction

  // A zero output width means no scaling. Otherwise the width is clamped to the
  // maximum upscale and then to the absolute column limit.
  function automatic int unsigned row_out_width();
    int unsigned w;
    int unsigned n;
    w = row_src_width();
    n = cur_out_width;
    if (n == 0) n = w;
    if (n > SCALE_LIMIT * w) n = SCALE_LIMIT * w;
    if (n > OUT_LIMIT) n = OUT_LIMIT;
    return n;
  endfunction

  function automatic void restart_row();
    src_col   = 0;
    out_col   = 0;
    out_acc   = 0;
    src_bound = row_out_width();
  endfunction

  function automatic logic [7:0] stretch5(input logic [4:0] v);
    int unsigned p;
    p = 32'(v) * 255;
    return 8'(p / 31);
  endfunction

  function automatic logic [23:0] rgb555_to_888(input logic [15:0] c);
    return {stretch5(c[14:10]), stretch5(c[9:5]), stretch5(c[4:0])};
  endfunction

  function automatic logic [23:0] decode_source(input logic [31:0] px);
    if (cur_format == FMT_ARGB1555) return rgb555_to_888(px[15:0]);
    if (cur_format == FMT_PALETTE) begin
      // Indices past the active color count read as black.
      if (px[7:0] >= cur_colors) return 24'h0;
      return palette_rgb[px[7:0]];
    end
    // ARGB8888, and the unused format code, pass the low 24 bits through.
    return px[23:0];
  endfunction

  function automatic void reset_model();
    cur_format    = FMT_ARGB1555;
    cur_src_width = 11'd256;
    cur_out_width = 13'd256;
    cur_colors    = 9'd256;
    restart_row();
  endfunction

  function automatic void apply_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_PIXEL_FORMAT: cur_format = v[1:0];
      CFG_SRC_WIDTH: begin
        cur_src_width = v[10:0];
        restart_row();
      end
      CFG_OUT_WIDTH: begin
        cur_out_width = v[12:0];
        restart_row();
      end
      CFG_COLOR_COUNT: cur_colors = v[8:0];
      default: ;
    endcase
  endfunction

  // Works out the output pixels caused by one transferred input item and queues them.
  // A source pixel covers every output column whose scaled position falls
  // inside it, at most the maximum upscale of them.
  function automatic void scale_pixel(input in_item_t item);
    int unsigned w;
    int unsigned n;
    logic [23:0] rgb;
    out_item_t batch [$];
    out_item_t o;
    if (item.kind) begin
      palette_rgb[item.palette_index] = rgb555_to_888(item.palette_entry);
      if (!slot_written[item.palette_index]) begin
        slot_written[item.palette_index] = 1'b1;
        written_slots.push_back(item.palette_index);
      end
      return;
    end
    w = row_src_width();
    n = row_out_width();
    rgb = decode_source(item.pixel_value);
    while (batch.size() < SCALE_LIMIT && out_col < n && out_acc < src_bound) begin
      o.red        = rgb[23:16];
      o.green      = rgb[15:8];
      o.blue       = rgb[7:0];
      o.out_column = out_col[OUT_COL_W-1:0];
      o.row_end    = (out_col == n - 1);
      o.last       = 1'b0;
      batch.push_back(o);
      out_col++;
      out_acc += w;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) pixels_due.push_back(batch[i]);
    src_col++;
    src_bound += n;
    if (src_col >= w) restart_row();
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Sends one item and returns at the rising edge where it transferred. Push is
  // left high so that back-to-back items stream without a bubble.
  task automatic send_item(input in_item_t item);
    @(negedge clk);
    if (idle_allowed && $urandom_range(0, 7) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    push    = 1'b1;
    in_item = item;
    do @(posedge clk); while (full);
    scale_pixel(item);
    items_sent++;
  endtask

  task automatic send_pixel(input logic [31:0] value);
    in_item_t item;
    item.kind          = 1'b0;
    item.pixel_value   = value;
    item.palette_index = 8'($urandom);
    item.palette_entry = 16'($urandom);
    send_item(item);
  endtask

  task automatic send_palette(input logic [7:0] slot, input logic [15:0] color);
    in_item_t item;
    item.kind          = 1'b1;
    item.pixel_value   = $urandom;
    item.palette_index = slot;
    item.palette_entry = color;
    send_item(item);
  endtask

  // Stops pushing and waits until every predicted output pixel has been popped,
  // then leaves room for anything still in flight inside the block.
  task automatic quiesce();
    @(negedge clk);
    push = 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, v);
  endtask

  // Writes all four registers while the block is idle.
  task automatic set_mode(input logic [1:0] fmt, input int unsigned sw,
                          input int unsigned ow, input int unsigned nc);
    quiesce();
    write_reg(CFG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
    write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(sw));
    write_reg(CFG_OUT_WIDTH, CFG_DATA_W'(ow));
    write_reg(CFG_COLOR_COUNT, CFG_DATA_W'(nc));
    @(negedge clk);
    cfg_valid = 1'b0;
    repeat (SETTLE) @(negedge clk);
    settings_used++;
  endtask

  // Picks a palette index that never reads a slot that was not written: an
  // unwritten index inside the active range is swapped for a written one.
  function automatic logic [7:0] safe_index();
    logic [7:0] idx;
    idx = 8'($urandom_range(0, 255));
    if (idx < cur_colors && !slot_written[idx])
      idx = written_slots[$urandom_range(0, written_slots.size() - 1)];
    return idx;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random pop stalls and the checker
  // ---------------------------------------------------------------------

  initial begin
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        pop = 1'b0;
        gap--;
      end else if (idle_allowed && $urandom_range(0, 9) == 0) begin
        pop = 1'b0;
        gap = $urandom_range(1, 7) - 1;
      end else begin
        pop = 1'b1;
      end
    end
  end

  // Every popped pixel is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      results_seen++;
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected output pixel col %0d rgb %02h%02h%02h", $realtime,
                   out_item.out_column, out_item.red, out_item.green, out_item.blue);
      end else begin
        want = pixels_due.pop_front();
        if (out_item.red !== want.red || out_item.green !== want.green ||
            out_item.blue !== want.blue || out_item.out_column !== want.out_column ||
            out_item.row_end !== want.row_end || out_item.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: pixel mismatch: expected rgb %02h%02h%02h col %0d end %b last %b",
                     $realtime, want.red, want.green, want.blue, want.out_column,
                     want.row_end, want.last);
            $display("    got rgb %02h%02h%02h col %0d end %b last %b",
                     out_item.red, out_item.green, out_item.blue, out_item.out_column,
                     out_item.row_end, out_item.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Out of reset the block runs ARGB1555 at one output per source pixel.
  // Black, white, pure red and the alpha bit are covered.
  task automatic test_reset_defaults();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h5A5A_7C00);
    send_pixel(32'h0000_83FF);
  endtask

  // ARGB8888 passes the low 24 bits. The unused format code behaves the same way.
  task automatic test_pixel_formats();
    set_mode(FMT_ARGB8888, 8, 8, 256);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hA5C3_E10F);
    set_mode(2'd3, 8, 8, 256);
    send_pixel(32'h5A3C_0F96);
  endtask

  // Loads palette slots at both ends of the index range and reads them back. It also
  // checks that a zero color count turns index FF black.
  task automatic test_palette();
    send_palette(8'h00, 16'hFC1F);
    send_palette(8'hFF, 16'h7FFF);
    send_palette(8'hAA, 16'h03E0);
    send_palette(8'h55, 16'h0000);
    set_mode(FMT_PALETTE, 4, 4, 256);
    send_pixel(32'hFFFF_FF00);
    send_pixel(32'h0000_00FF);
    send_pixel(32'h1234_56AA);
    set_mode(FMT_PALETTE, 4, 4, 0);
    send_pixel(32'h0000_00FF);
  endtask

  // Covers the width clamps: full upscale, heavy downscale where trailing pixels
  // give nothing, zero widths, saturated widths and an out_width past four times.
  task automatic test_width_extremes();
    set_mode(FMT_ARGB1555, 1, 4, 256);
    send_pixel(32'h0000_7FFF);
    send_pixel(32'h0000_1234);
    set_mode(FMT_ARGB1555, 3, 1, 256);
    send_pixel(32'h0000_001F);
    send_pixel(32'h0000_03E0);
    send_pixel(32'h0000_7C00);
    set_mode(FMT_ARGB1555, 0, 0, 256);
    send_pixel(32'h0000_4210);
    set_mode(FMT_ARGB8888, 2047, 8191, 256);
    send_pixel(32'h0012_3456);
    send_pixel(32'h00FE_DCBA);
    set_mode(FMT_ARGB1555, 3, 13, 256);
    send_pixel(32'h0000_1111);
    send_pixel(32'h0000_2222);
    send_pixel(32'h0000_3333);
  endtask

  // Random settings, each followed by a stream of pixels that, at the short widths, completes
  // rows, with some palette writes mixed in. Most rows are short so they wrap often.
  // A few settings use very large widths to reach the saturation paths.
  task automatic test_random_rows();
    int unsigned sw;
    int unsigned w;
    int unsigned ow;
    int unsigned nc;
    logic [1:0]  fmt;
    logic [31:0] px;
    for (int phase = 0; phase < 8; phase++) begin
      // One setting runs with no idling on either side.
      idle_allowed = (phase != 3);
      fmt = ($urandom_range(0, 2) == 0) ? FMT_PALETTE : 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: sw = $urandom_range(100, 2047);
        1: sw = 0;
        default: sw = $urandom_range(1, 12);
      endcase
      w = (sw == 0) ? 1 : (sw > SRC_LIMIT ? SRC_LIMIT : sw);
      case ($urandom_range(0, 7))
        0: ow = 0;
        1: ow = $urandom_range(0, 8191);
        default: ow = $urandom_range(1, SCALE_LIMIT * w + 2);
      endcase
      nc = ($urandom_range(0, 5) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
      set_mode(fmt, sw, ow, nc);
      for (int k = 0; k < 32; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          send_palette(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end else begin
          px = $urandom;
          if (cur_format == FMT_PALETTE) px[7:0] = safe_index();
          send_pixel(px);
        end
      end
    end
  endtask

  // The last part of the run pushes and pops with no idle gaps; only full holds the input.
  task automatic test_steady_stream();
    set_mode(FMT_ARGB1555, 5, 17, 256);
    idle_allowed = 1'b0;
    for (int k = 0; k < 30; k++) send_pixel($urandom);
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst          = 1'b1;
    push         = 1'b0;
    pop          = 1'b0;
    in_item      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_PIXEL_FORMAT;
    cfg_data     = '0;
    idle_allowed = 1'b1;
    mismatches   = 0;
    items_sent   = 0;
    results_seen = 0;
    settings_used = 0;
    foreach (slot_written[i]) slot_written[i] = 1'b0;
    reset_model();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The block reloads its row bound shortly after reset.
    repeat (SETTLE) @(negedge clk);

    test_reset_defaults();
    test_pixel_formats();
    test_palette();
    test_width_extremes();
    test_random_rows();
    test_steady_stream();

    @(negedge clk);
    push = 1'b0;
    waited = 0;
    while (pixels_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE * 2) @(negedge clk);
    if (pixels_due.size() != 0) begin
      mismatches++;
      $display("%0d predicted output pixels never arrived", pixels_due.size());
    end

    $display("Sent %0d items under %0d register settings; %0d output pixels popped and checked.",
             items_sent, settings_used, results_seen);
    $display("Covered ARGB1555, palette and ARGB8888 input, width clamps, row wrap and stalls.");
    if (mismatches == 0) begin
      $display("pixel_expand_nearest_hscale regression: pass");
    end else begin
      $display("pixel_expand_nearest_hscale regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/phe_pkg.sv
rtl/phe_front.sv
rtl/phe_fifo.sv
rtl/phe_back.sv
rtl/pixel_expand_nearest_hscale.sv
test/testbench.sv
